>>> rtl/jmsf_pkg.sv
// Shared types and constants for the JPEG marker segment filter.
`timescale 1ns / 1ps

package jmsf_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	// Marker byte values
	localparam logic [7:0] BYTE_FF   = 8'hFF;
	localparam logic [7:0] CODE_SOI  = 8'hD8;
	localparam logic [7:0] CODE_EOI  = 8'hD9;
	localparam logic [7:0] CODE_DQT  = 8'hDB;
	localparam logic [7:0] CODE_DHT  = 8'hC4;
	localparam logic [7:0] CODE_SOF0 = 8'hC0;
	localparam logic [7:0] CODE_SOF1 = 8'hC1;
	localparam logic [7:0] CODE_SOF2 = 8'hC2;
	localparam logic [7:0] CODE_SOS  = 8'hDA;
	localparam logic [7:0] CODE_DRI  = 8'hDD;

	// Result kinds
	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_NO_MARKER   = 3'd1;
	localparam logic [2:0] ERR_NO_SOI      = 3'd2;
	localparam logic [2:0] ERR_MARK_MISS   = 3'd3;
	localparam logic [2:0] ERR_EOI         = 3'd4;
	localparam logic [2:0] ERR_PROGRESSIVE = 3'd5;
	localparam logic [2:0] ERR_TRUNCATED   = 3'd6;
	localparam logic [2:0] ERR_BAD_LENGTH  = 3'd7;

	// Register map (word index)
	localparam logic REG_ALLOW_PROGRESSIVE = 1'b0;

	// At most one command per accepted byte: an optional FF beat, an optional
	// data beat and an optional tail (summary or error) beat, in that order.
	typedef struct packed {
		logic        pre_ff;
		logic        data_en;
		logic [7:0]  data;
		logic        tail_en;
		logic [1:0]  tail_kind;
		logic [2:0]  err;
		logic [15:0] width;
		logic [15:0] height;
		logic [31:0] length;
	} cmd_t;

endpackage

>>> rtl/jmsf_if.sv
// Valid/ready channel interfaces for the filter input and result streams.
`timescale 1ns / 1ps

interface jmsf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface jmsf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_kind;
	logic [7:0]  out_byte;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic [31:0] emitted_length;
	logic [2:0]  error_code;
	logic        run_last;

	modport source (output valid, output out_kind, output out_byte, output image_width,
		output image_height, output emitted_length, output error_code, output run_last,
		input ready);
	modport sink   (input valid, input out_kind, input out_byte, input image_width,
		input image_height, input emitted_length, input error_code, input run_last,
		output ready);
endinterface

>>> rtl/jmsf_front.sv
// Byte parser: walks marker segments; at most one command per byte.
`timescale 1ns / 1ps

module jmsf_front (
	input  logic             clk,
	input  logic             arst_n,
	jmsf_in_if.sink          in_ch,
	input  logic             queue_full,
	input  logic             allow_progressive,
	output logic             push,
	output jmsf_pkg::cmd_t   cmd
);

	localparam logic [3:0] PH_FIRST = 4'd0;
	localparam logic [3:0] PH_SOI   = 4'd1;
	localparam logic [3:0] PH_MARK  = 4'd2;
	localparam logic [3:0] PH_CODE  = 4'd3;
	localparam logic [3:0] PH_LENHI = 4'd4;
	localparam logic [3:0] PH_LENLO = 4'd5;
	localparam logic [3:0] PH_BODY  = 4'd6;
	localparam logic [3:0] PH_SCAN  = 4'd7;
	localparam logic [3:0] PH_DRAIN = 4'd8;

	localparam logic [1:0] ACT_DROP   = 2'd0;
	localparam logic [1:0] ACT_COPY   = 2'd1;
	localparam logic [1:0] ACT_HEADER = 2'd2;

	logic [3:0]  phase_q, phase_d;
	logic [1:0]  action_q, action_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] left_q, left_d;
	logic [2:0]  hidx_q, hidx_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [31:0] total_q, total_d;

	logic        accept;
	logic        failed;
	logic [2:0]  fail_code;
	logic [1:0]  count_inc;
	logic [15:0] seg_len;
	logic [32:0] total_sum;
	logic [7:0]  b;

	assign in_ch.ready = !queue_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign b           = in_ch.in_byte;
	assign seg_len     = {len_hi_q, b};

	always_comb begin
		phase_d   = phase_q;
		action_d  = action_q;
		len_hi_d  = len_hi_q;
		left_d    = left_q;
		hidx_d    = hidx_q;
		width_d   = width_q;
		height_d  = height_q;
		failed    = 1'b0;
		fail_code = jmsf_pkg::ERR_NONE;
		count_inc = 2'd0;
		cmd       = '0;

		case (phase_q)
			PH_FIRST: begin
				if (b != jmsf_pkg::BYTE_FF) begin
					failed    = 1'b1;
					fail_code = jmsf_pkg::ERR_NO_MARKER;
				end else begin
					phase_d = PH_SOI;
				end
			end
			PH_SOI: begin
				if (b != jmsf_pkg::CODE_SOI) begin
					failed    = 1'b1;
					fail_code = jmsf_pkg::ERR_NO_SOI;
				end else begin
					cmd.pre_ff  = 1'b1;
					cmd.data_en = 1'b1;
					cmd.data    = b;
					phase_d     = PH_MARK;
				end
			end
			PH_MARK: begin
				if (b != jmsf_pkg::BYTE_FF) begin
					failed    = 1'b1;
					fail_code = jmsf_pkg::ERR_MARK_MISS;
				end else begin
					phase_d = PH_CODE;
				end
			end
			PH_CODE: begin
				if (b == jmsf_pkg::CODE_EOI) begin
					failed    = 1'b1;
					fail_code = jmsf_pkg::ERR_EOI;
				end else if (b == jmsf_pkg::CODE_SOS) begin
					cmd.pre_ff  = 1'b1;
					cmd.data_en = 1'b1;
					cmd.data    = b;
					count_inc   = 2'd2;
					phase_d     = PH_SCAN;
				end else if (b == jmsf_pkg::CODE_SOF2 && !allow_progressive) begin
					failed    = 1'b1;
					fail_code = jmsf_pkg::ERR_PROGRESSIVE;
				end else begin
					if (b == jmsf_pkg::CODE_SOF0 || b == jmsf_pkg::CODE_SOF1
						|| b == jmsf_pkg::CODE_SOF2) begin
						action_d = ACT_HEADER;
					end else if (b == jmsf_pkg::CODE_DQT || b == jmsf_pkg::CODE_DHT
						|| b == jmsf_pkg::CODE_DRI) begin
						action_d = ACT_COPY;
					end else begin
						action_d = ACT_DROP;
					end
					if (action_d != ACT_DROP) begin
						cmd.pre_ff  = 1'b1;
						cmd.data_en = 1'b1;
						cmd.data    = b;
						count_inc   = 2'd2;
					end
					phase_d = PH_LENHI;
				end
			end
			PH_LENHI: begin
				len_hi_d = b;
				if (action_q != ACT_DROP) begin
					cmd.data_en = 1'b1;
					cmd.data    = b;
					count_inc   = 2'd1;
				end
				phase_d = PH_LENLO;
			end
			PH_LENLO: begin
				if (action_q != ACT_DROP) begin
					cmd.data_en = 1'b1;
					cmd.data    = b;
					count_inc   = 2'd1;
				end
				if (seg_len < 16'd2 || (action_q == ACT_HEADER && seg_len < 16'd7)) begin
					failed    = 1'b1;
					fail_code = jmsf_pkg::ERR_BAD_LENGTH;
				end else begin
					left_d  = seg_len - 16'd2;
					hidx_d  = 3'd0;
					phase_d = (seg_len != 16'd2) ? PH_BODY : PH_MARK;
				end
			end
			PH_BODY: begin
				if (action_q != ACT_DROP) begin
					cmd.data_en = 1'b1;
					cmd.data    = b;
					count_inc   = 2'd1;
				end
				if (action_q == ACT_HEADER && hidx_q < 3'd5) begin
					case (hidx_q)
						3'd1:    height_d[15:8] = b;
						3'd2:    height_d[7:0]  = b;
						3'd3:    width_d[15:8]  = b;
						3'd4:    width_d[7:0]   = b;
						default: ;
					endcase
					hidx_d = hidx_q + 3'd1;
				end
				left_d = left_q - 16'd1;
				if (left_q == 16'd1) begin
					phase_d = PH_MARK;
				end
			end
			PH_SCAN: begin
				cmd.data_en = 1'b1;
				cmd.data    = b;
				count_inc   = 2'd1;
			end
			PH_DRAIN: ;
			default: phase_d = PH_DRAIN;
		endcase

		if (failed) begin
			phase_d       = PH_DRAIN;
			cmd.tail_en   = 1'b1;
			cmd.tail_kind = jmsf_pkg::KIND_ERROR;
			cmd.err       = fail_code;
		end

		// Saturate the emitted count at all ones
		total_sum = {1'b0, total_q} + {31'd0, count_inc};
		total_d   = total_sum[32] ? '1 : total_sum[31:0];

		if (in_ch.in_last) begin
			if (!failed) begin
				if (phase_d == PH_SCAN) begin
					cmd.tail_en   = 1'b1;
					cmd.tail_kind = jmsf_pkg::KIND_SUMMARY;
					cmd.width     = width_d;
					cmd.height    = height_d;
					cmd.length    = total_d;
				end else if (phase_d != PH_DRAIN) begin
					cmd.tail_en   = 1'b1;
					cmd.tail_kind = jmsf_pkg::KIND_ERROR;
					cmd.err       = jmsf_pkg::ERR_TRUNCATED;
				end
			end
			phase_d  = PH_FIRST;
			action_d = ACT_DROP;
			len_hi_d = '0;
			left_d   = '0;
			hidx_d   = '0;
			width_d  = '0;
			height_d = '0;
			total_d  = '0;
		end
	end

	assign push = accept && (cmd.pre_ff || cmd.data_en || cmd.tail_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			action_q <= ACT_DROP;
			len_hi_q <= '0;
			left_q   <= '0;
			hidx_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			total_q  <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			action_q <= action_d;
			len_hi_q <= len_hi_d;
			left_q   <= left_d;
			hidx_q   <= hidx_d;
			width_q  <= width_d;
			height_q <= height_d;
			total_q  <= total_d;
		end
	end

endmodule

>>> rtl/jmsf_cmd_queue.sv
// Short command queue between the parser and the result sequencer.
`timescale 1ns / 1ps

module jmsf_cmd_queue #(
	parameter int DEPTH = jmsf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jmsf_pkg::cmd_t push_cmd,
	input  logic           pop,
	output jmsf_pkg::cmd_t head,
	output logic           empty,
	output logic           full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	jmsf_pkg::cmd_t   entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head  = entries_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_FULL);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/jmsf_back.sv
// Result sequencer: expands commands into result beats through an output register.
`timescale 1ns / 1ps

module jmsf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  jmsf_pkg::cmd_t head,
	input  logic           empty,
	output logic           pop,
	jmsf_out_if.source     out_ch
);

	logic        valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [31:0] length_q;
	logic [2:0]  err_q;
	logic        last_q;

	// Beats of the head command already sent: bit 0 FF, bit 1 data, bit 2 tail
	logic [2:0]  used_q;
	logic [2:0]  remain;
	logic [2:0]  pick;
	logic        pick_last;
	logic        load;

	assign remain    = {head.tail_en, head.data_en, head.pre_ff} & ~used_q;
	assign pick      = remain & (~remain + 3'd1);
	assign pick_last = (remain == pick);
	assign load      = !empty && (!valid_q || out_ch.ready);
	assign pop       = load && pick_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			used_q  <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			used_q  <= pick_last ? 3'd0 : (used_q | pick);
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= pick_last;
			if (pick[2]) begin
				kind_q   <= head.tail_kind;
				byte_q   <= '0;
				width_q  <= head.width;
				height_q <= head.height;
				length_q <= head.length;
				err_q    <= head.err;
			end else begin
				kind_q   <= jmsf_pkg::KIND_DATA;
				byte_q   <= pick[0] ? jmsf_pkg::BYTE_FF : head.data;
				width_q  <= '0;
				height_q <= '0;
				length_q <= '0;
				err_q    <= jmsf_pkg::ERR_NONE;
			end
		end
	end

	assign out_ch.valid          = valid_q;
	assign out_ch.out_kind       = kind_q;
	assign out_ch.out_byte       = byte_q;
	assign out_ch.image_width    = width_q;
	assign out_ch.image_height   = height_q;
	assign out_ch.emitted_length = length_q;
	assign out_ch.error_code     = err_q;
	assign out_ch.run_last       = last_q;

endmodule

>>> rtl/jpeg_marker_segment_filter_top.sv
// Top level of the JPEG marker segment filter: parser, command queue, sequencer, register.
// Path: each accepted byte's command is queued, then its beats load the output register.
// Throughput: one byte per cycle while the queue has room; the sequencer sends one
//   result beat per cycle while the receiver is ready, so a marker code or final byte
//   that yields two or three beats is absorbed by the QUEUE_DEPTH-entry command queue.
// Reset: arst_n clears the parser to expect the first marker byte, empties the queue and
//   output register, and sets allow_progressive to 0; no clearing pass follows.
`timescale 1ns / 1ps

module jpeg_marker_segment_filter_top #(
	parameter int QUEUE_DEPTH = jmsf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	jmsf_in_if.sink     in_ch,
	jmsf_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration register. The word index sits above the byte offset bits;
	// writes to any other word are ignored and read back as zero.
	logic allow_prog_q;
	logic cfg_write;
	logic sel_allow;

	assign pready    = 1'b1;
	assign sel_allow = (paddr[2] == jmsf_pkg::REG_ALLOW_PROGRESSIVE);
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = sel_allow ? {31'd0, allow_prog_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_prog_q <= 1'b0;
		end else if (cfg_write && sel_allow) begin
			allow_prog_q <= pwdata[0];
		end
	end

	// Front to back command path
	jmsf_pkg::cmd_t push_cmd;
	jmsf_pkg::cmd_t head_cmd;
	logic           push;
	logic           pop;
	logic           q_empty;
	logic           q_full;

	// Parser: accepts a byte whenever the queue has room, advances the segment
	// walk and issues the command for that byte's result beats.
	jmsf_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_ch             (in_ch),
		.queue_full        (q_full),
		.allow_progressive (allow_prog_q),
		.push              (push),
		.cmd               (push_cmd)
	);

	// Decouple the parser from output stalls
	jmsf_cmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	// Sequencer: sends the head command's beats in order, one per cycle while the receiver
	// is ready, marking run_last on the final one.
	jmsf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head_cmd),
		.empty  (q_empty),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

>>> verif/jmsf_stream_checker.sv
// Beat checker for the JPEG marker segment filter: predicts result beats per input byte and compares.
`timescale 1ns / 1ps

module jmsf_stream_checker
	import jmsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	jmsf_in_if          in_ch,
	jmsf_out_if         out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        end_check,
	output int          fail_count,
	output int          pending,
	output int          beats_checked
);

	localparam logic [2:0] ALLOW_PROG_ADDR = {REG_ALLOW_PROGRESSIVE, 2'b00};
	localparam int         MAX_PRINTS      = 40;

	typedef enum logic [3:0] {
		ST_FIRST, ST_SOI, ST_MARK, ST_CODE, ST_LEN_HI, ST_LEN_LO, ST_BODY, ST_SCAN, ST_DRAIN
	} parse_state_e;

	typedef enum logic [1:0] {SEG_DROP, SEG_COPY, SEG_FRAME} seg_action_e;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  value;
		logic [15:0] img_w;
		logic [15:0] img_h;
		logic [31:0] total;
		logic [2:0]  err;
		logic        last_beat;
	} beat_t;

	// predictor state and register copy
	logic         allow_prog;
	parse_state_e st;
	seg_action_e  seg;
	logic [7:0]   len_hi;
	logic [15:0]  body_left;
	logic [2:0]   hdr_idx;
	logic [15:0]  frame_w;
	logic [15:0]  frame_h;
	logic [31:0]  out_total;

	beat_t expected_beats[$];
	beat_t step_beats[3];
	int    step_n;
	beat_t want;

	int fails     = 0;
	int beats_seen = 0;
	int pending_r = 0;
	bit leftover_flagged = 0;

	assign fail_count    = fails;
	assign pending       = pending_r;
	assign beats_checked = beats_seen;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_val);
		if (fails < MAX_PRINTS)
			$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
		fails++;
	endtask

	task automatic clear_parse();
		st        = ST_FIRST;
		seg       = SEG_DROP;
		len_hi    = '0;
		body_left = '0;
		hdr_idx   = '0;
		frame_w   = '0;
		frame_h   = '0;
		out_total = '0;
	endtask

	task automatic stage(input logic [1:0] kind, input logic [7:0] value, input logic [15:0] w,
		input logic [15:0] h, input logic [31:0] total, input logic [2:0] err);
		step_beats[step_n] = '{kind: kind, value: value, img_w: w, img_h: h, total: total,
			err: err, last_beat: 1'b0};
		step_n++;
	endtask

	task automatic emit(input logic [7:0] value, input bit counted);
		stage(KIND_DATA, value, '0, '0, '0, ERR_NONE);
		if (counted && out_total != 32'hFFFF_FFFF)
			out_total++;
	endtask

	task automatic raise_error(input logic [2:0] code);
		st = ST_DRAIN;
		stage(KIND_ERROR, '0, '0, '0, '0, code);
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic last);
		logic [15:0] seg_len;
		bit          failed;
		step_n = 0;
		failed = 0;
		case (st)
		ST_FIRST: begin
			if (b != BYTE_FF) begin
				raise_error(ERR_NO_MARKER);
				failed = 1;
			end else
				st = ST_SOI;
		end
		ST_SOI: begin
			if (b != CODE_SOI) begin
				raise_error(ERR_NO_SOI);
				failed = 1;
			end else begin
				emit(BYTE_FF, 0);
				emit(CODE_SOI, 0);
				st = ST_MARK;
			end
		end
		ST_MARK: begin
			if (b != BYTE_FF) begin
				raise_error(ERR_MARK_MISS);
				failed = 1;
			end else
				st = ST_CODE;
		end
		ST_CODE: begin
			if (b == CODE_EOI) begin
				raise_error(ERR_EOI);
				failed = 1;
			end else if (b == CODE_SOS) begin
				emit(BYTE_FF, 1);
				emit(CODE_SOS, 1);
				st = ST_SCAN;
			end else if (b == CODE_SOF2 && !allow_prog) begin
				raise_error(ERR_PROGRESSIVE);
				failed = 1;
			end else begin
				if (b == CODE_SOF0 || b == CODE_SOF1 || b == CODE_SOF2)
					seg = SEG_FRAME;
				else if (b == CODE_DQT || b == CODE_DHT || b == CODE_DRI)
					seg = SEG_COPY;
				else
					seg = SEG_DROP;
				if (seg != SEG_DROP) begin
					emit(BYTE_FF, 1);
					emit(b, 1);
				end
				st = ST_LEN_HI;
			end
		end
		ST_LEN_HI: begin
			len_hi = b;
			if (seg != SEG_DROP)
				emit(b, 1);
			st = ST_LEN_LO;
		end
		ST_LEN_LO: begin
			if (seg != SEG_DROP)
				emit(b, 1);
			seg_len = {len_hi, b};
			if (seg_len < 16'd2 || (seg == SEG_FRAME && seg_len < 16'd7)) begin
				raise_error(ERR_BAD_LENGTH);
				failed = 1;
			end else begin
				body_left = seg_len - 16'd2;
				hdr_idx   = '0;
				st        = (body_left != 0) ? ST_BODY : ST_MARK;
			end
		end
		ST_BODY: begin
			if (seg != SEG_DROP)
				emit(b, 1);
			if (seg == SEG_FRAME && hdr_idx < 3'd5) begin
				case (hdr_idx)
				3'd1: frame_h[15:8] = b;
				3'd2: frame_h[7:0]  = b;
				3'd3: frame_w[15:8] = b;
				3'd4: frame_w[7:0]  = b;
				default: ;
				endcase
				hdr_idx++;
			end
			body_left--;
			if (body_left == 0)
				st = ST_MARK;
		end
		ST_SCAN: emit(b, 1);
		default: st = ST_DRAIN;
		endcase

		if (last) begin
			if (!failed) begin
				if (st == ST_SCAN)
					stage(KIND_SUMMARY, '0, frame_w, frame_h, out_total, ERR_NONE);
				else if (st != ST_DRAIN)
					stage(KIND_ERROR, '0, '0, '0, '0, ERR_TRUNCATED);
			end
			clear_parse();
		end

		if (step_n > 0)
			step_beats[step_n - 1].last_beat = 1'b1;
		for (int i = 0; i < step_n; i++)
			expected_beats.push_back(step_beats[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_beats.delete();
			allow_prog = 1'b0;
			clear_parse();
			pending_r = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				beats_seen++;
				if (expected_beats.size() == 0)
					report("beat with nothing expected, kind", 32'(out_ch.out_kind), '0);
				else begin
					want = expected_beats.pop_front();
					if (out_ch.out_kind !== want.kind)
						report("out_kind", 32'(out_ch.out_kind), 32'(want.kind));
					if (out_ch.out_byte !== want.value)
						report("out_byte", 32'(out_ch.out_byte), 32'(want.value));
					if (out_ch.image_width !== want.img_w)
						report("image_width", 32'(out_ch.image_width), 32'(want.img_w));
					if (out_ch.image_height !== want.img_h)
						report("image_height", 32'(out_ch.image_height), 32'(want.img_h));
					if (out_ch.emitted_length !== want.total)
						report("emitted_length", out_ch.emitted_length, want.total);
					if (out_ch.error_code !== want.err)
						report("error_code", 32'(out_ch.error_code), 32'(want.err));
					if (out_ch.run_last !== want.last_beat)
						report("run_last", 32'(out_ch.run_last), 32'(want.last_beat));
				end
			end
			if (in_ch.valid && in_ch.ready)
				parse_byte(in_ch.in_byte, in_ch.in_last);
			if (psel && penable && pwrite && pready && paddr == ALLOW_PROG_ADDR)
				allow_prog = pwdata[0];
			if (end_check && !leftover_flagged && expected_beats.size() != 0) begin
				report("beats never delivered", '0, 32'(expected_beats.size()));
				leftover_flagged = 1;
			end
			pending_r = expected_beats.size();
		end
	end

endmodule

>>> verif/jpeg_marker_segment_filter_top_test.sv
// Testbench top for the JPEG marker segment filter: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module jpeg_marker_segment_filter_top_test;
	import jmsf_pkg::*;

	localparam logic [2:0] ALLOW_PROG_ADDR = {REG_ALLOW_PROGRESSIVE, 2'b00};
	// cycles with no beat on either channel before the run is declared hung
	localparam int WATCHDOG_LIMIT  = 5000;
	// long receiver stall used to fill the command queue and back up the input
	localparam int HOLD_OFF_CYCLES = 300;
	// margin after the last predicted beat, before register writes and the end
	localparam int DRAIN_CYCLES    = 8;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        end_check;

	int fail_count;
	int pending;
	int beats_checked;

	int hold_requests;
	int bytes_sent;
	int files_sent;
	int burst_left;
	bit sender_steady;

	logic [7:0] file_bytes[$];

	jmsf_in_if  in_ch();
	jmsf_out_if out_ch();

	jpeg_marker_segment_filter_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// The checker watches both channels and the register port on its own.
	jmsf_stream_checker u_beat_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.end_check     (end_check),
		.fail_count    (fail_count),
		.pending       (pending),
		.beats_checked (beats_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offer one byte and hold it until the block takes it. Between bursts drop valid
	// for a random gap; in steady stretches keep valid up back to back.
	task automatic send_byte(input logic [7:0] value, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = sender_steady ? 0 : $urandom_range(0, 5);
			repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
			burst_left = $urandom_range(1, 10);
		end
		@(negedge clk);
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= value;
		in_ch.in_last <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// Send the staged file, marking its final byte.
	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		files_sent++;
	endtask

	// Drop valid, wait until every predicted beat has arrived, then let the pipe settle.
	task automatic wait_drained();
		@(negedge clk) in_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the write lands on the edge with pready high.
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Append one marker segment. Mostly sane lengths; now and then a length that is
	// too short, and rarely a huge length after which the file is cut in the body.
	task automatic push_segment(output bit stop);
		int         pick;
		int         seg_len;
		logic [7:0] code;
		bit         frame;
		stop = 0;
		pick = $urandom_range(0, 9);
		case (pick)
		0: code = CODE_DQT;
		1: code = CODE_DHT;
		2: code = CODE_DRI;
		3: code = CODE_SOF0;
		4: code = CODE_SOF1;
		5: code = CODE_SOF2;
		6: code = BYTE_FF;      // fill byte: FF FF reads as a dropped code FF
		7: code = 8'($urandom_range(8'hE0, 8'hEF));
		default: code = 8'($urandom_range(0, 255));
		endcase
		frame = (code == CODE_SOF0 || code == CODE_SOF1 || code == CODE_SOF2);
		file_bytes.push_back(BYTE_FF);
		file_bytes.push_back(code);
		if ($urandom_range(0, 19) == 0) begin
			file_bytes.push_back(8'($urandom_range(1, 255)));
			file_bytes.push_back(8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
			stop = 1;
		end else begin
			if ($urandom_range(0, 11) == 0)
				seg_len = frame ? $urandom_range(0, 6) : $urandom_range(0, 1);
			else
				seg_len = frame ? $urandom_range(7, 10) : $urandom_range(2, 6);
			file_bytes.push_back(8'h00);
			file_bytes.push_back(8'(seg_len));
			if (seg_len > 2)
				repeat (seg_len - 2) file_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Build one random file: mostly SOI, a few segments and a short scan; the rest is
	// noise. Occasionally corrupt one byte or cut the file short.
	task automatic compose_file();
		int segs;
		int cut;
		bit stop;
		file_bytes.delete();
		stop = 0;
		if ($urandom_range(0, 9) < 8) begin
			file_bytes.push_back(BYTE_FF);
			file_bytes.push_back(CODE_SOI);
			segs = $urandom_range(0, 3);
			for (int i = 0; i < segs && !stop; i++)
				push_segment(stop);
			if (!stop && $urandom_range(0, 9) < 8) begin
				file_bytes.push_back(BYTE_FF);
				file_bytes.push_back(CODE_SOS);
				repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end else begin
			repeat ($urandom_range(1, 5)) file_bytes.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1) == 0)
				file_bytes[0] = BYTE_FF;
		end
		if ($urandom_range(0, 9) == 0)
			file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, file_bytes.size());
			while (file_bytes.size() > cut)
				void'(file_bytes.pop_back());
		end
	endtask

	// Keep sending random files until this phase has moved enough bytes.
	task automatic random_phase(input int target);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < target) begin
			sender_steady = ($urandom_range(0, 3) == 0);
			compose_file();
			send_file();
		end
	endtask

	// Receiver: change the stall pattern at random intervals (always ready, random,
	// periodic). On request hold ready low for a long stretch counted here.
	initial begin : receiver
		int hold_served;
		int mode;
		int span;
		int period;
		int phase_cnt;
		hold_served   = 0;
		mode          = 0;
		span          = 0;
		period        = 2;
		phase_cnt     = 0;
		out_ch.ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_served) begin
				hold_served++;
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else begin
				if (span == 0) begin
					mode      = $urandom_range(0, 2);
					span      = $urandom_range(16, 80);
					period    = $urandom_range(2, 5);
					phase_cnt = 0;
				end
				span--;
				phase_cnt++;
				case (mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 99) < 65);
				default: out_ch.ready <= (phase_cnt % period != 0);
				endcase
			end
		end
	end

	// Watchdog: end the run when neither channel has moved a beat for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
		$display("jpeg_marker_segment_filter_top_test: FAIL");
		$finish;
	end

	initial begin : stimulus
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.in_byte = '0;
		in_ch.in_last = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		end_check     = 1'b0;
		hold_requests = 0;
		bytes_sent    = 0;
		files_sent    = 0;
		burst_left    = 0;
		sender_steady = 0;

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed files, progressive still disallowed from reset.
		// first byte is not FF
		file_bytes = '{8'h00};
		send_file();
		// FF not followed by SOI
		file_bytes = '{BYTE_FF, 8'h00};
		send_file();
		// no marker after SOI, on the final byte
		file_bytes = '{BYTE_FF, CODE_SOI, 8'h7F};
		send_file();
		// EOI before the scan; the trailing byte falls into the drain
		file_bytes = '{BYTE_FF, CODE_SOI, BYTE_FF, CODE_EOI, BYTE_FF};
		send_file();
		// progressive frame while disallowed
		file_bytes = '{BYTE_FF, CODE_SOI, BYTE_FF, CODE_SOF2};
		send_file();
		// segment length of one is too short
		file_bytes = '{BYTE_FF, CODE_SOI, BYTE_FF, CODE_DQT, 8'h00, 8'h01};
		send_file();
		// minimal frame header, height 0xFFFF width 1, then scan and summary
		file_bytes = '{BYTE_FF, CODE_SOI, BYTE_FF, CODE_SOF0, 8'h00, 8'h07,
			8'h08, 8'hFF, 8'hFF, 8'h00, 8'h01, BYTE_FF, CODE_SOS, 8'hFF};
		send_file();
		// file ends before the scan marker
		file_bytes = '{BYTE_FF, CODE_SOI, BYTE_FF};
		send_file();

		// Random phases over both register settings; write only when idle.
		wait_drained();
		apb_write(ALLOW_PROG_ADDR, 32'd1);
		random_phase(8);

		wait_drained();
		apb_write(ALLOW_PROG_ADDR, 32'd0);
		random_phase(8);

		wait_drained();
		apb_write(ALLOW_PROG_ADDR, 32'hFFFF_FFFF);
		random_phase(8);

		// Pressure: stall the receiver while a long scan streams in back to back, so
		// the command queue fills and the block pushes back on its input.
		file_bytes = '{BYTE_FF, CODE_SOI, BYTE_FF, CODE_SOS};
		repeat (20) file_bytes.push_back(8'($urandom_range(0, 255)));
		sender_steady = 1;
		hold_requests++;
		send_file();

		wait_drained();
		@(negedge clk) end_check <= 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);

		$display("run covered %0d files, %0d bytes in, %0d result beats checked",
			files_sent, bytes_sent, beats_checked);
		$display("both allow_progressive settings, every error kind, and a long output stall");
		if (fail_count == 0)
			$display("jpeg_marker_segment_filter_top_test: PASS");
		else
			$display("jpeg_marker_segment_filter_top_test: FAIL");
		$finish;
	end

endmodule
